>>> sv/data_processing_instruction_encoder_macros.svh
// Assertion macros for the data-processing instruction encoder checker.
// Depends on a clk and a rst signal in the scope where the macros are used.
`ifndef DATA_PROCESSING_INSTRUCTION_ENCODER_MACROS_SVH
`define DATA_PROCESSING_INSTRUCTION_ENCODER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define DPIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpie check failed");

// Next-cycle implication, ignored while reset is high.
`define DPIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpie check failed");

// Next-cycle implication that also holds across reset.
`define DPIE_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpie reset check failed");

`endif

>>> sv/dpie_pkg.sv
// Shared types, codes and helpers for the data-processing instruction encoder.
// No dependencies; imported by every pipeline stage and the top level.
package dpie_pkg;

  localparam logic [3:0] CMD_MOVE = 4'b1101;
  localparam logic [31:0] IMM8_MASK = 32'h0000_00FF;
  localparam int unsigned ROT_STEPS = 16;

  localparam logic [1:0] FORM_RD_RN_SRC2 = 2'd0;
  localparam logic [1:0] FORM_RN_SRC2 = 2'd1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_IMM = 2'd1;
  localparam logic [1:0] ST_BAD_SHIFT = 2'd2;

  localparam int unsigned IN_BITS = 63;

  // Input word, last field in the lowest bits.
  typedef struct packed {
    logic [31:0] imm_value;
    logic [3:0]  rs;
    logic [3:0]  rm;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic        src2_is_imm;
    logic        shift_alias;
    logic [1:0]  form;
    logic [1:0]  shift_type;
    logic        set_flags;
    logic [3:0]  cmd;
    logic [3:0]  cond;
  } in_t;

  // After decode and the rotation-window checks.
  typedef struct packed {
    logic [3:0]  cond;
    logic [3:0]  cmd;
    logic        set_flags;
    logic        iflag;
    logic        is_shift;
    logic        src2_is_imm;
    logic [1:0]  shift_type;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [3:0]  rs;
    logic [31:0] imm_value;
    logic        shift_big;
    logic [ROT_STEPS-1:0] fit;
  } s1_t;

  // After operand selection.
  typedef struct packed {
    logic [3:0]  cond;
    logic [3:0]  cmd;
    logic        set_flags;
    logic        iflag;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic [11:0] src2;
    logic [1:0]  status;
  } s2_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] machine_word;
  } res_t;

  // imm8 window rotated right by 2*k.
  function automatic logic [31:0] rot_window(input int unsigned k);
    logic [63:0] dbl;
    dbl = {IMM8_MASK, IMM8_MASK} >> (2 * k);
    return dbl[31:0];
  endfunction

endpackage

>>> sv/dpie_fit.sv
// Stage 1: operand decode, register zeroing by form, rotation-window checks.
// Depends on dpie_pkg.
module dpie_fit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dpie_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dpie_pkg::s1_t  out_data
);
  import dpie_pkg::*;

  s1_t stage_next;

  always_comb begin
    stage_next.cond = in_data.cond;
    stage_next.cmd = in_data.cmd;
    stage_next.set_flags = in_data.set_flags;
    stage_next.is_shift = (in_data.cmd == CMD_MOVE) && in_data.shift_alias;
    stage_next.iflag = !stage_next.is_shift && in_data.src2_is_imm;
    stage_next.src2_is_imm = in_data.src2_is_imm;
    stage_next.shift_type = in_data.shift_type;
    stage_next.rd = (in_data.form == FORM_RN_SRC2) ? 4'd0 : in_data.rd;
    stage_next.rn = (in_data.form == FORM_RN_SRC2 || in_data.form == FORM_RD_RN_SRC2) ?
                    in_data.rn : 4'd0;
    stage_next.rm = in_data.rm;
    stage_next.rs = in_data.rs;
    stage_next.imm_value = in_data.imm_value;
    stage_next.shift_big = |in_data.imm_value[31:5];
    for (int unsigned k = 0; k < ROT_STEPS; k++) begin
      stage_next.fit[k] = ~|(in_data.imm_value & ~rot_window(k));
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

>>> sv/dpie_sel.sv
// Stage 2: smallest fitting rotation, Src2 field and status selection.
// Depends on dpie_pkg.
module dpie_sel (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dpie_pkg::s1_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dpie_pkg::s2_t  out_data
);
  import dpie_pkg::*;

  s2_t         stage_next;
  logic [3:0]  rot_k;
  logic [7:0]  rot_byte;
  logic [63:0] dbl;

  // Scan from the top so the lowest fitting rotation wins.
  always_comb begin
    dbl = {in_data.imm_value, in_data.imm_value};
    rot_k = 4'd0;
    rot_byte = 8'd0;
    for (int k = ROT_STEPS - 1; k >= 0; k--) begin
      if (in_data.fit[k]) begin
        rot_k = 4'(k);
        rot_byte = dbl[32 - 2 * k +: 8];
      end
    end
  end

  always_comb begin
    stage_next.cond = in_data.cond;
    stage_next.cmd = in_data.cmd;
    stage_next.set_flags = in_data.set_flags;
    stage_next.iflag = in_data.iflag;
    stage_next.rd = in_data.rd;
    stage_next.rn = in_data.rn;
    stage_next.src2 = 12'd0;
    stage_next.status = ST_OK;
    if (in_data.is_shift) begin
      if (in_data.src2_is_imm) begin
        if (in_data.shift_big) begin
          stage_next.status = ST_BAD_SHIFT;
        end else begin
          stage_next.src2 = {in_data.imm_value[4:0], in_data.shift_type, 1'b0, in_data.rm};
        end
      end else begin
        stage_next.src2 = {in_data.rs, 1'b0, in_data.shift_type, 1'b1, in_data.rm};
      end
    end else if (in_data.iflag) begin
      if (in_data.fit == '0) begin
        stage_next.status = ST_BAD_IMM;
      end else begin
        stage_next.src2 = {rot_k, rot_byte};
      end
    end else begin
      stage_next.src2 = {8'd0, in_data.rm};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

>>> sv/dpie_pack.sv
// Stage 3: word assembly and output register; errors force the word to zero.
// Depends on dpie_pkg.
module dpie_pack (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dpie_pkg::s2_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dpie_pkg::res_t out_data
);
  import dpie_pkg::*;

  res_t stage_next;

  always_comb begin
    stage_next.status = in_data.status;
    if (in_data.status != ST_OK) begin
      stage_next.machine_word = 32'd0;
    end else begin
      stage_next.machine_word = {in_data.cond, 2'b00, in_data.iflag, in_data.cmd,
                                 in_data.set_flags, in_data.rn, in_data.rd, in_data.src2};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

>>> sv/data_processing_instruction_encoder.sv
// Top level of the data-processing instruction encoder.
// Depends on dpie_pkg, dpie_fit, dpie_sel and dpie_pack.
//
// Usage:
//   One parsed data-processing instruction goes in per s_ word; one encoded
//   32-bit instruction plus a status code comes out per m_ word, in order.
//   Status: ok, immediate not encodable, or shift amount above 31; on either
//   error the machine word is zero.
// Pipeline: a word accepted into the stage 1 register moves on through the
//   stage 2 register into the output register (stage 1 decodes and runs the
//   sixteen rotation-window checks, stage 2 picks the smallest rotation and
//   builds Src2, stage 3 assembles the word in the output reg).
// Throughput: one word per cycle while m_tready stays high; each stage holds
//   one word and refills in the cycle its contents move on.
// Stall: when m_tready is low the output register holds its word; as the
//   stages behind it fill, up to three words sit in the pipe before s_tready
//   drops. Nothing is dropped or repeated.
// Reset: rst (synchronous, active high) clears all stage valid bits; the
//   block holds no other control state and is ready in the cycle after reset.
module data_processing_instruction_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cond[3:0] cmd[7:4] set_flags[8] shift_type[10:9] form[12:11]
  // shift_alias[13] src2_is_imm[14] rd[18:15] rn[22:19] rm[26:23]
  // rs[30:27] imm_value[62:31], bit 63 ignored
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // machine_word[31:0] status[33:32], bits 39:34 zero
  output logic [39:0] m_tdata
);
  import dpie_pkg::*;

  in_t  in_word;
  s1_t  s1_data;
  s2_t  s2_data;
  res_t res_data;
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;

  assign in_word = in_t'(s_tdata[IN_BITS-1:0]);

  dpie_fit u_fit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_word),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  dpie_sel u_sel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  dpie_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_data)
  );

  // Pad to whole bytes.
  assign m_tdata = {6'd0, res_data};

endmodule

>>> sv/dpie_checker.sv
// Port-level checker for the data-processing instruction encoder, with bind.
// Depends on dpie_pkg and data_processing_instruction_encoder_macros.svh.
`include "data_processing_instruction_encoder_macros.svh"

module dpie_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import dpie_pkg::*;

  logic [1:0] out_status;

  assign out_status = m_tdata[33:32];

  // Stalled result holds.
  `DPIE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // Errors always carry a zero word; status code 3 never appears.
  `DPIE_ASSERT_NOW(a_err_zero, m_tvalid && out_status != ST_OK, m_tdata[31:0] == 32'd0)
  `DPIE_ASSERT_NOW(a_status_code, m_tvalid,
                   out_status == ST_OK || out_status == ST_BAD_IMM || out_status == ST_BAD_SHIFT)
  // Nothing waiting at the output: the whole pipe can take a word.
  `DPIE_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready)
  // Reset empties the pipe.
  `DPIE_ASSERT_RST(a_reset, rst, !m_tvalid)

endmodule

bind data_processing_instruction_encoder dpie_checker u_dpie_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/data_processing_instruction_encoder_checker.sv
// Output checker for the data-processing instruction encoder testbench.
// Depends on dpie_pkg; watches both stream ports, predicts each encoded word.
module data_processing_instruction_encoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          mismatch_count,
  output int          words_checked,
  output int          bad_imm_seen,
  output int          bad_shift_seen,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dpie_pkg::*;

  res_t pending_encodings[$];

  // Encoding of one instruction: word plus status, word zero on any error.
  function automatic res_t encode_instruction(in_t w);
    logic [3:0]  rd_f;
    logic [3:0]  rn_f;
    logic        shifting;
    logic        ibit;
    logic [11:0] op2;
    logic [1:0]  st;
    logic [63:0] dbl;
    logic [31:0] rotl;
    logic [3:0]  rot_k;
    bit          found;
    res_t        r;
    rd_f = w.rd;
    rn_f = w.rn;
    if (w.form == FORM_RN_SRC2) begin
      rd_f = '0;
    end else if (w.form != FORM_RD_RN_SRC2) begin
      rn_f = '0;
    end
    shifting = (w.cmd == CMD_MOVE) && w.shift_alias;
    ibit = shifting ? 1'b0 : w.src2_is_imm;
    op2 = '0;
    st = ST_OK;
    if (shifting) begin
      if (w.src2_is_imm) begin
        if (w.imm_value > 32'd31) st = ST_BAD_SHIFT;
        else op2 = {w.imm_value[4:0], w.shift_type, 1'b0, w.rm};
      end else begin
        op2 = {w.rs, 1'b0, w.shift_type, 1'b1, w.rm};
      end
    end else if (ibit) begin
      // value fits rotation k when rotating it left by 2k leaves only 8 low bits
      found = 1'b0;
      for (int k = 0; k < 16; k++) begin
        dbl = {w.imm_value, w.imm_value} << (2 * k);
        rotl = dbl[63:32];
        if (!found && rotl[31:8] == '0) begin
          found = 1'b1;
          rot_k = 4'(k);
          op2 = {rot_k, rotl[7:0]};
        end
      end
      if (!found) st = ST_BAD_IMM;
    end else begin
      op2 = {8'h00, w.rm};
    end
    r.status = st;
    if (st != ST_OK) r.machine_word = '0;
    else r.machine_word = {w.cond, 2'b00, ibit, w.cmd, w.set_flags, rn_f, rd_f, op2};
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      pending_encodings.delete();
      mismatch_count = 0;
      words_checked = 0;
      bad_imm_seen = 0;
      bad_shift_seen = 0;
      words_pending = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_encodings.push_back(encode_instruction(in_t'(s_tdata[62:0])));
      end
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[33:0]);
        if (pending_encodings.size() == 0) begin
          $display("%0t: output word expected none actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = pending_encodings.pop_front();
          words_checked++;
          if (want.status == ST_BAD_IMM) bad_imm_seen++;
          if (want.status == ST_BAD_SHIFT) bad_shift_seen++;
          if (got.machine_word !== want.machine_word) begin
            $display("%0t: machine_word expected %h actual %h", $time,
                     want.machine_word, got.machine_word);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
            mismatch_count++;
          end
          if (m_tdata[39:34] !== '0) begin
            $display("%0t: padding expected 00 actual %h", $time, m_tdata[39:34]);
            mismatch_count++;
          end
        end
      end
      words_pending = pending_encodings.size();
    end
  end

endmodule

>>> dv/data_processing_instruction_encoder_tb.sv
// Testbench top for the data-processing instruction encoder.
// Depends on dpie_pkg, the encoder RTL and data_processing_instruction_encoder_checker.
module data_processing_instruction_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpie_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int HOLD_CYCLES = 80;

  // forms and shift kinds only named here for the directed words
  localparam logic [1:0] FORM_RD_SRC2 = 2'd2;
  localparam logic [1:0] FORM_RD_RM_SHIFT = 2'd3;
  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  int mismatch_count;
  int words_checked;
  int bad_imm_seen;
  int bad_shift_seen;
  int words_pending;

  // pacing knobs, percent of cycles
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_armed;
  int cycle_count;

  data_processing_instruction_encoder dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  data_processing_instruction_encoder_checker checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .mismatch_count(mismatch_count),
    .words_checked(words_checked),
    .bad_imm_seen(bad_imm_seen),
    .bad_shift_seen(bad_shift_seen),
    .words_pending(words_pending)
  );

  always #4 clk = ~clk;

  function automatic in_t make_instr(logic [3:0] cond, logic [3:0] cmd, logic s,
                                     logic [1:0] sht, logic [1:0] form, logic alias_bit,
                                     logic imm_bit, logic [3:0] rd, logic [3:0] rn,
                                     logic [3:0] rm, logic [3:0] rs, logic [31:0] imm);
    in_t w;
    w.cond = cond;
    w.cmd = cmd;
    w.set_flags = s;
    w.shift_type = sht;
    w.form = form;
    w.shift_alias = alias_bit;
    w.src2_is_imm = imm_bit;
    w.rd = rd;
    w.rn = rn;
    w.rm = rm;
    w.rs = rs;
    w.imm_value = imm;
    return w;
  endfunction

  // Mostly well-formed: move/shift family weighted up, immediates mostly
  // encodable, shift amounts mostly in range; the rest is raw noise.
  function automatic in_t random_instr();
    in_t         w;
    int          pick;
    logic [31:0] imm8;
    logic [63:0] dbl;
    w.cond = 4'($urandom_range(15));
    w.cmd = ($urandom_range(99) < 40) ? CMD_MOVE : 4'($urandom_range(15));
    w.set_flags = 1'($urandom_range(1));
    w.shift_type = 2'($urandom_range(3));
    w.form = 2'($urandom_range(3));
    if (w.cmd == CMD_MOVE) w.shift_alias = ($urandom_range(99) < 60);
    else w.shift_alias = 1'($urandom_range(1));
    w.src2_is_imm = 1'($urandom_range(1));
    w.rd = 4'($urandom_range(15));
    w.rn = 4'($urandom_range(15));
    w.rm = 4'($urandom_range(15));
    w.rs = 4'($urandom_range(15));
    pick = $urandom_range(99);
    imm8 = 32'($urandom_range(255));
    if (w.cmd == CMD_MOVE && w.shift_alias) begin
      if (pick < 80) w.imm_value = $urandom_range(31);
      else if (pick < 88) w.imm_value = 32'd32;
      else if (pick < 94) w.imm_value = $urandom;
      else w.imm_value = 32'hFFFF_FFFF;
    end else if (pick < 45) begin
      dbl = {imm8, imm8} >> (2 * $urandom_range(15));
      w.imm_value = dbl[31:0];
    end else if (pick < 60) begin
      // any rotation, odd ones are usually not encodable
      dbl = {imm8, imm8} >> $urandom_range(31);
      w.imm_value = dbl[31:0];
    end else if (pick < 75) begin
      w.imm_value = $urandom_range(511);
    end else begin
      w.imm_value = $urandom;
    end
    return w;
  endfunction

  // Offer one word, with random idle cycles first; returns after acceptance.
  task automatic send_instr(in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_instr(random_instr());
  endtask

  // Receiver side: one long hold-off once armed, else random stalls.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_t directed[$];
    logic [3:0] c;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Every command once, spreading the other fields around.
    for (int i = 0; i < 16; i++) begin
      c = 4'(i);
      directed.push_back(make_instr(c ^ 4'hA, c, c[0], c[1:0], c[3:2], c[1], c[2],
                                    c, ~c, c + 4'd3, ~c + 4'd1,
                                    32'h3F << (2 * i)));
    end
    // all zero; all ones (immediate that cannot be encoded)
    directed.push_back(make_instr(4'h0, 4'h0, 1'b0, SHIFT_LSL, FORM_RD_RN_SRC2, 1'b0, 1'b0,
                                  4'h0, 4'h0, 4'h0, 4'h0, 32'h0));
    directed.push_back(make_instr(4'hF, 4'hF, 1'b1, SHIFT_ROR, FORM_RD_RM_SHIFT, 1'b1, 1'b1,
                                  4'hF, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF));
    // immediates: no rotation, top byte, wrap across bit 0, odd shift
    directed.push_back(make_instr(4'hE, 4'h4, 1'b0, SHIFT_LSL, FORM_RD_RN_SRC2, 1'b0, 1'b1,
                                  4'h1, 4'h2, 4'h3, 4'h4, 32'h0000_00FF));
    directed.push_back(make_instr(4'hE, CMD_MOVE, 1'b1, SHIFT_LSL, FORM_RD_SRC2, 1'b0, 1'b1,
                                  4'h5, 4'h6, 4'h7, 4'h8, 32'hFF00_0000));
    directed.push_back(make_instr(4'h1, 4'h2, 1'b0, SHIFT_LSL, FORM_RN_SRC2, 1'b0, 1'b1,
                                  4'h9, 4'hA, 4'hB, 4'hC, 32'hF000_000F));
    directed.push_back(make_instr(4'h2, 4'hA, 1'b1, SHIFT_LSL, FORM_RN_SRC2, 1'b0, 1'b1,
                                  4'h3, 4'h4, 4'h5, 4'h6, 32'h0000_01FE));
    // shifts by immediate: largest legal amount, just over, far over
    directed.push_back(make_instr(4'hE, CMD_MOVE, 1'b0, SHIFT_ASR, FORM_RD_RM_SHIFT, 1'b1,
                                  1'b1, 4'h2, 4'h3, 4'hD, 4'h0, 32'd31));
    directed.push_back(make_instr(4'hE, CMD_MOVE, 1'b0, SHIFT_LSR, FORM_RD_RM_SHIFT, 1'b1,
                                  1'b1, 4'h2, 4'h3, 4'hD, 4'h0, 32'd32));
    directed.push_back(make_instr(4'hE, CMD_MOVE, 1'b1, SHIFT_LSL, FORM_RD_RM_SHIFT, 1'b1,
                                  1'b1, 4'h2, 4'h3, 4'hD, 4'h0, 32'hFFFF_FFFF));
    // shift by register
    directed.push_back(make_instr(4'h0, CMD_MOVE, 1'b1, SHIFT_ROR, FORM_RD_RM_SHIFT, 1'b1,
                                  1'b0, 4'hE, 4'h1, 4'h7, 4'hF, 32'h0));
    // plain register move stays register form
    directed.push_back(make_instr(4'hE, CMD_MOVE, 1'b0, SHIFT_LSR, FORM_RD_SRC2, 1'b0, 1'b0,
                                  4'h4, 4'h9, 4'hC, 4'h3, 32'h1234_5678));
    // shift alias on another command is ignored
    directed.push_back(make_instr(4'hE, 4'h4, 1'b0, SHIFT_ASR, FORM_RD_RN_SRC2, 1'b1, 1'b0,
                                  4'h1, 4'h2, 4'h3, 4'h4, 32'd40));
    // shift alias under forms that keep Rn or zero Rd
    directed.push_back(make_instr(4'h3, CMD_MOVE, 1'b0, SHIFT_LSL, FORM_RD_RN_SRC2, 1'b1, 1'b1,
                                  4'h6, 4'h8, 4'hA, 4'hB, 32'd5));
    directed.push_back(make_instr(4'h3, CMD_MOVE, 1'b1, SHIFT_LSR, FORM_RN_SRC2, 1'b1, 1'b0,
                                  4'h6, 4'h8, 4'hA, 4'hB, 32'd0));

    foreach (directed[i]) send_instr(directed[i]);

    // Phase 1: no idling, opened by a long output hold-off so the pipe backs up.
    hold_armed = 1'b1;
    run_random(RANDOM_PER_PHASE);
    // Phase 2: sender idles often.
    send_idle_pct = 57;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
    // Phase 3: receiver stalls often.
    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_random(RANDOM_PER_PHASE);
    // Phase 4: both sides throttle.
    send_idle_pct = 31;
    recv_stall_pct = 31;
    run_random(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;

    // Drain: wait for every expected word, then a few cycles for strays.
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Checked %0d encoded words (%0d bad immediates, %0d bad shift amounts)",
             words_checked, bad_imm_seen, bad_shift_seen);
    $display("across free-running, sender-idle, receiver-stall, mixed and hold-off pacing");
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatch_count, words_pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/dpie_pkg.sv
sv/dpie_fit.sv
sv/dpie_sel.sv
sv/dpie_pack.sv
sv/data_processing_instruction_encoder.sv
sv/dpie_checker.sv
dv/data_processing_instruction_encoder_checker.sv
dv/data_processing_instruction_encoder_tb.sv
